// ===== rtl/core/dab_dp_pkg.sv =====
package dab_dp_pkg;

  localparam int SOFT_W       = 8;
  localparam int SOFT_BITS    = 8;
  localparam int SOFT_MAX     = (1 << (SOFT_BITS - 1)) - 1;
  localparam int SOFT_MIN     = -SOFT_MAX - 1;

  localparam int NUM_VECTORS  = 24;
  localparam int VECTOR_LEN   = 32;
  localparam int TAIL_LEN     = 24;
  localparam int TAIL_VECTOR  = 8;
  localparam int NUM_SECTIONS = 4;
  localparam int MAX_OUT      = 4;

  localparam int VEC_W   = 5;
  localparam int LEN_W   = 9;
  localparam int UNIT_W  = 7;
  localparam int POS_W   = 16;
  localparam int SEC_W   = 3;
  localparam int VP_W    = $clog2(VECTOR_LEN);
  localparam int CNT_W   = $clog2(MAX_OUT);
  localparam int IDX_W   = 3;
  localparam int CDATA_W = 9;

  // register indexes
  localparam logic [IDX_W-1:0] REG_VECTOR_SEC1 = 3'd0;
  localparam logic [IDX_W-1:0] REG_LENGTH_SEC1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_VECTOR_SEC2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_LENGTH_SEC2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_VECTOR_SEC3 = 3'd4;
  localparam logic [IDX_W-1:0] REG_LENGTH_SEC3 = 3'd5;
  localparam logic [IDX_W-1:0] REG_VECTOR_SEC4 = 3'd6;
  localparam logic [IDX_W-1:0] REG_LENGTH_SEC4 = 3'd7;

  typedef struct packed {
    logic [NUM_SECTIONS-1:0][VEC_W-1:0] vector;
    logic [NUM_SECTIONS-1:0][LEN_W-1:0] length;
  } cfg_t;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [POS_W-1:0] pos;
    logic [VP_W-1:0]  vp;
  } pos_t;

  typedef struct packed {
    logic is_last;
    logic next_kept;
  } trk_info_t;

  // kept positions per group of four within a 32-position vector
  localparam logic [2:0] KEEP_COUNT [NUM_VECTORS][8] = '{
    '{3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1}, '{3'd2,3'd1,3'd1,3'd1,3'd2,3'd1,3'd1,3'd1},
    '{3'd2,3'd1,3'd2,3'd1,3'd2,3'd1,3'd1,3'd1}, '{3'd2,3'd1,3'd2,3'd1,3'd2,3'd1,3'd2,3'd1},
    '{3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd2,3'd1}, '{3'd2,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd1},
    '{3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1}, '{3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2},
    '{3'd3,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2}, '{3'd3,3'd2,3'd2,3'd2,3'd3,3'd2,3'd2,3'd2},
    '{3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd2,3'd2}, '{3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2},
    '{3'd3,3'd3,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2}, '{3'd3,3'd3,3'd3,3'd2,3'd3,3'd3,3'd3,3'd2},
    '{3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd2}, '{3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3},
    '{3'd4,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3,3'd3}, '{3'd4,3'd3,3'd3,3'd3,3'd4,3'd3,3'd3,3'd3},
    '{3'd4,3'd3,3'd4,3'd3,3'd4,3'd3,3'd3,3'd3}, '{3'd4,3'd3,3'd4,3'd3,3'd4,3'd3,3'd4,3'd3},
    '{3'd4,3'd4,3'd4,3'd3,3'd4,3'd3,3'd4,3'd3}, '{3'd4,3'd4,3'd4,3'd3,3'd4,3'd4,3'd4,3'd3},
    '{3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd3}, '{3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4,3'd4}
  };

  // vec is already clamped to 1..NUM_VECTORS
  function automatic logic keep_at(input logic [VEC_W-1:0] vec, input logic [VP_W-1:0] vp);
    logic [VEC_W-1:0] row;
    logic [2:0]       cnt;
    row = vec - VEC_W'(1);
    cnt = KEEP_COUNT[row][vp[VP_W-1:2]];
    return {1'b0, vp[1:0]} < cnt;
  endfunction

endpackage

// ===== rtl/core/dab_dp_cfg.sv =====
module dab_dp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [dab_dp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dab_dp_pkg::CDATA_W-1:0]   cfg_wdata,
  output dab_dp_pkg::cfg_t                 cfg
);

  dab_dp_pkg::cfg_t cfg_r;
  dab_dp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        dab_dp_pkg::REG_VECTOR_SEC1: cfg_nxt.vector[0] = cfg_wdata[dab_dp_pkg::VEC_W-1:0];
        dab_dp_pkg::REG_LENGTH_SEC1: cfg_nxt.length[0] = cfg_wdata;
        dab_dp_pkg::REG_VECTOR_SEC2: cfg_nxt.vector[1] = cfg_wdata[dab_dp_pkg::VEC_W-1:0];
        dab_dp_pkg::REG_LENGTH_SEC2: cfg_nxt.length[1] = cfg_wdata;
        dab_dp_pkg::REG_VECTOR_SEC3: cfg_nxt.vector[2] = cfg_wdata[dab_dp_pkg::VEC_W-1:0];
        dab_dp_pkg::REG_LENGTH_SEC3: cfg_nxt.length[2] = cfg_wdata;
        dab_dp_pkg::REG_VECTOR_SEC4: cfg_nxt.vector[3] = cfg_wdata[dab_dp_pkg::VEC_W-1:0];
        dab_dp_pkg::REG_LENGTH_SEC4: cfg_nxt.length[3] = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dab_dp_pkg::NUM_SECTIONS; i++) begin
        cfg_r.vector[i] <= dab_dp_pkg::VEC_W'(1);
        cfg_r.length[i] <= '0;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/dab_dp_trk.sv =====
module dab_dp_trk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  dab_dp_pkg::cfg_t      cfg,
  output dab_dp_pkg::trk_info_t info
);

  localparam logic [dab_dp_pkg::SEC_W-1:0] SEC_TAIL = dab_dp_pkg::SEC_W'(dab_dp_pkg::NUM_SECTIONS);
  localparam logic [dab_dp_pkg::POS_W-1:0] TAIL_END = dab_dp_pkg::POS_W'(dab_dp_pkg::TAIL_LEN - 1);

  dab_dp_pkg::pos_t st_r;
  dab_dp_pkg::pos_t st_nxt;
  dab_dp_pkg::pos_t eff;
  dab_dp_pkg::pos_t stepped;

  // skip finished or empty sections, clamp tail position
  function automatic dab_dp_pkg::pos_t settle(input dab_dp_pkg::pos_t s, input dab_dp_pkg::cfg_t c);
    dab_dp_pkg::pos_t r;
    logic [dab_dp_pkg::POS_W-1:0] len;
    r = s;
    if (r.sec > SEC_TAIL) r.sec = SEC_TAIL;
    for (int i = 0; i < dab_dp_pkg::NUM_SECTIONS; i++) begin
      len = {c.length[i], {dab_dp_pkg::UNIT_W{1'b0}}};
      if (r.sec == dab_dp_pkg::SEC_W'(i) && r.pos >= len) begin
        r.sec = dab_dp_pkg::SEC_W'(i + 1);
        r.pos = '0;
      end
    end
    if (r.sec == SEC_TAIL && r.pos > TAIL_END) r.pos = TAIL_END;
    return r;
  endfunction

  function automatic logic [dab_dp_pkg::VEC_W-1:0] sec_vector(
    input logic [dab_dp_pkg::SEC_W-1:0] sec, input dab_dp_pkg::cfg_t c);
    logic [dab_dp_pkg::VEC_W-1:0] v;
    if (sec >= SEC_TAIL) begin
      v = dab_dp_pkg::VEC_W'(dab_dp_pkg::TAIL_VECTOR);
    end else begin
      v = c.vector[sec[1:0]];
      if (v == '0) v = dab_dp_pkg::VEC_W'(1);
      if (v > dab_dp_pkg::VEC_W'(dab_dp_pkg::NUM_VECTORS))
        v = dab_dp_pkg::VEC_W'(dab_dp_pkg::NUM_VECTORS);
    end
    return v;
  endfunction

  always_comb begin
    dab_dp_pkg::pos_t raw;
    eff          = settle(st_r, cfg);
    info.is_last = (eff.sec == SEC_TAIL) && (eff.pos == TAIL_END);
    raw.sec      = eff.sec;
    raw.pos      = eff.pos + dab_dp_pkg::POS_W'(1);
    raw.vp       = eff.vp + dab_dp_pkg::VP_W'(1);
    stepped      = settle(raw, cfg);
    info.next_kept = dab_dp_pkg::keep_at(sec_vector(stepped.sec, cfg), stepped.vp);
  end

  always_comb begin
    st_nxt = st_r;
    if (adv) begin
      // frame end returns everything to the first section
      if (info.is_last) st_nxt = '0;
      else              st_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/core/dab_depuncturer.sv =====
// DAB depuncturer: expands received soft values into one mother-code frame.
// Input channel in_valid/in_ready carries one soft word; output channel
// out_valid/out_ready carries one depunctured word per handshake with its
// erased and frame_last flags. A frame is four sections of length*128
// positions, each with its own puncturing vector, then a 24-position tail.
// Each input word yields its own value followed by up to three zero words
// at punctured positions; the output register issues one word per cycle
// while the receiver is ready, and that sets the rate. An accepted word is
// held in a register before its first output word is registered at the
// output. A new input word is taken in the cycle its predecessor's last
// output word is registered, so single-result words flow every cycle while
// the receiver is ready. Configuration registers (cfg_wr_en, cfg_index,
// cfg_wdata) must be written only while the block is idle, which the block
// does not enforce; the position tracker reads them live. Synchronous
// active-low reset empties the pipeline, returns the frame position to the
// start and loads the register defaults. On a receiver stall the output
// word holds, generation pauses and input waits while a word is pending.
module dab_depuncturer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [dab_dp_pkg::SOFT_W-1:0]   in_soft_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dab_dp_pkg::SOFT_W-1:0]   out_soft_out,
  output logic                                   out_erased,
  output logic                                   out_frame_last,
  input  logic                                   cfg_wr_en,
  input  logic [dab_dp_pkg::IDX_W-1:0]           cfg_index,
  input  logic [dab_dp_pkg::CDATA_W-1:0]         cfg_wdata
);

  dab_dp_pkg::cfg_t      cfg;
  dab_dp_pkg::trk_info_t info;

  logic                                 busy_r, busy_nxt;
  logic                                 first_r, first_nxt;
  logic [dab_dp_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [dab_dp_pkg::SOFT_W-1:0] soft_r, soft_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [dab_dp_pkg::SOFT_W-1:0] out_soft_r, out_soft_nxt;
  logic                                 out_erased_r, out_erased_nxt;
  logic                                 out_last_r, out_last_nxt;
  logic signed [dab_dp_pkg::SOFT_W-1:0] sat;
  logic                                 emit, done, accept;

  dab_dp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dab_dp_trk u_trk (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (emit),
    .cfg   (cfg),
    .info  (info)
  );

  always_comb begin
    if (int'(in_soft_in) > dab_dp_pkg::SOFT_MAX)
      sat = dab_dp_pkg::SOFT_W'(dab_dp_pkg::SOFT_MAX);
    else if (int'(in_soft_in) < dab_dp_pkg::SOFT_MIN)
      sat = dab_dp_pkg::SOFT_W'(dab_dp_pkg::SOFT_MIN);
    else
      sat = in_soft_in;
  end

  assign emit = busy_r && (!out_valid_r || out_ready);
  // word finishes at frame end, after four results, or before a kept position
  assign done = info.is_last || (cnt_r == dab_dp_pkg::CNT_W'(dab_dp_pkg::MAX_OUT - 1)) ||
                info.next_kept;
  assign in_ready = !busy_r || (emit && done);
  assign accept   = in_valid && in_ready;

  always_comb begin
    busy_nxt  = busy_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    soft_nxt  = soft_r;
    if (emit) begin
      first_nxt = 1'b0;
      cnt_nxt   = cnt_r + dab_dp_pkg::CNT_W'(1);
      if (done) busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      cnt_nxt   = '0;
      soft_nxt  = sat;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_soft_nxt   = out_soft_r;
    out_erased_nxt = out_erased_r;
    out_last_nxt   = out_last_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_soft_nxt   = first_r ? soft_r : '0;
      out_erased_nxt = !first_r;
      out_last_nxt   = info.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      first_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      first_r     <= first_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    soft_r       <= soft_nxt;
    out_soft_r   <= out_soft_nxt;
    out_erased_r <= out_erased_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_soft_out   = out_soft_r;
  assign out_erased     = out_erased_r;
  assign out_frame_last = out_last_r;

`ifndef SYNTH
  a_erased_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_erased_r |-> out_soft_r == '0)
    else $error("erased word carries a non-zero value");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && first_r && cnt_r == '0)
    else $error("accepted word not loaded for emission");

  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && first_r |-> cnt_r == '0)
    else $error("kept value pending after zeros were issued");

  a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && (out_erased_r == !$past(first_r)))
    else $error("emitted word not registered at the output");
`endif

endmodule

// ===== bench/tb_dab_depuncturer.sv =====
`timescale 1ns / 100ps

module tb_dab_depuncturer;
  import dab_dp_pkg::*;

  localparam int SAT_BITS  = 8;
  localparam int SAT_HI    = (1 << (SAT_BITS - 1)) - 1;
  localparam int SAT_LO    = -SAT_HI - 1;
  localparam int SECTIONS  = 4;
  localparam int SEC_UNIT  = 128;
  localparam int TAIL_POS  = 24;
  localparam int TAIL_PI   = 8;
  localparam int MAX_WORDS = 4;
  localparam int HOLD_CYCLES = 300;

  localparam logic [IDX_W-1:0] VEC_REGS [SECTIONS] =
    '{REG_VECTOR_SEC1, REG_VECTOR_SEC2, REG_VECTOR_SEC3, REG_VECTOR_SEC4};
  localparam logic [IDX_W-1:0] LEN_REGS [SECTIONS] =
    '{REG_LENGTH_SEC1, REG_LENGTH_SEC2, REG_LENGTH_SEC3, REG_LENGTH_SEC4};

  typedef struct packed {
    logic signed [SOFT_W-1:0] sval;
    logic                     erased;
    logic                     last;
  } word_t;

  typedef struct packed {
    logic                     is_write;
    logic [IDX_W-1:0]         reg_idx;
    logic [CDATA_W-1:0]       reg_data;
    logic signed [SOFT_W-1:0] sval;
    logic                     typed;
    logic [1:0]               zeros;
    logic                     ends;
  } step_row_t;

  // after reset only the tail is live (PI8): one word, then a word with two
  // zeros, alternating; the twelfth word closes the frame
  localparam step_row_t DIRECTED [25] = '{
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sh80,   1'b1, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sh7F,   1'b1, 2'd2, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd0,    1'b1, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     -8'sd1,   1'b1, 2'd2, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd1,    1'b1, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sh55,   1'b1, 2'd2, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'shAA,   1'b1, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd64,   1'b1, 2'd2, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     -8'sd65,  1'b1, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd2,    1'b1, 2'd2, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     -8'sd3,   1'b1, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd100,  1'b1, 2'd2, 1'b1},
    // vector 0 behaves as PI1, one section of 128
    '{1'b1, REG_VECTOR_SEC1, 9'd0,     8'sd0,    1'b0, 2'd0, 1'b0},
    '{1'b1, REG_LENGTH_SEC1, 9'd1,     8'sd0,    1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     -8'sd100, 1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd55,   1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     -8'sd7,   1'b0, 2'd0, 1'b0},
    // 31 behaves as PI24, upper data bits ignored
    '{1'b1, REG_VECTOR_SEC1, 9'h1FF,   8'sd0,    1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd120,  1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     -8'sd120, 1'b0, 2'd0, 1'b0},
    // back to PI1 mid-frame: next word lands on a punctured position
    '{1'b1, REG_VECTOR_SEC1, 9'h1E1,   8'sd0,    1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd33,   1'b0, 2'd0, 1'b0},
    // section shortened under the current position: straight to the tail
    '{1'b1, REG_LENGTH_SEC1, 9'd0,     8'sd0,    1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     -8'sd50,  1'b0, 2'd0, 1'b0},
    '{1'b0, REG_VECTOR_SEC1, 9'd0,     8'sd77,   1'b0, 2'd0, 1'b0}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SOFT_W-1:0] in_soft_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [SOFT_W-1:0] out_soft_out;
  logic                     out_erased;
  logic                     out_frame_last;
  logic                     cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [CDATA_W-1:0]       cfg_wdata = '0;

  dab_depuncturer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_soft_in     (in_soft_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_soft_out   (out_soft_out),
    .out_erased     (out_erased),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frame tracker and register copy
  logic [VEC_W-1:0] vec_reg [SECTIONS] = '{default: VEC_W'(1)};
  logic [LEN_W-1:0] len_reg [SECTIONS] = '{default: '0};
  logic [2:0]       cur_sec = '0;
  logic [15:0]      cur_pos = '0;
  logic [4:0]       cur_vp  = '0;

  word_t expected_words[$];
  int    mismatches = 0;
  int    words_in = 0;
  int    words_out = 0;
  int    frames_done = 0;
  int    reg_writes = 0;
  int    tx_idle_pct = 15;
  int    rx_idle_pct = 67;
  bit    hold_req = 1'b0;
  int    hold_left = 0;

  function automatic int section_positions(input int s);
    if (s < SECTIONS) return int'(len_reg[s]) * SEC_UNIT;
    return TAIL_POS;
  endfunction

  function automatic int active_vector();
    int n;
    if (cur_sec >= SECTIONS) return TAIL_PI;
    n = int'(vec_reg[cur_sec[1:0]]);
    if (n < 1) n = 1;
    if (n > 24) n = 24;
    return n;
  endfunction

  function automatic void skip_done_sections();
    if (cur_sec > SECTIONS) cur_sec = 3'(SECTIONS);
    while (cur_sec < SECTIONS && int'(cur_pos) >= section_positions(cur_sec)) begin
      cur_sec = cur_sec + 3'd1;
      cur_pos = '0;
    end
    if (cur_sec == SECTIONS && cur_pos >= TAIL_POS) cur_pos = 16'(TAIL_POS - 1);
  endfunction

  // PIn keeps base = 1 + (n-1)/8 of every four, and (n-1)%8 + 1 groups keep
  // one more; those groups are picked in bit-reversed group order
  function automatic bit position_kept();
    int         n;
    int         base;
    int         extra;
    logic [2:0] grp;
    logic [2:0] rank;
    n     = active_vector();
    base  = (n - 1) / 8 + 1;
    extra = (n - 1) % 8 + 1;
    grp   = cur_vp[4:2];
    rank  = {grp[0], grp[1], grp[2]};
    return int'(cur_vp[1:0]) < base + ((int'(rank) < extra) ? 1 : 0);
  endfunction

  function automatic bit at_frame_end();
    return cur_sec == SECTIONS && cur_pos == TAIL_POS - 1;
  endfunction

  function automatic bit step_position();
    if (at_frame_end()) begin
      cur_sec = '0;
      cur_pos = '0;
      cur_vp  = '0;
      return 1'b1;
    end
    cur_pos = cur_pos + 16'd1;
    cur_vp  = cur_vp + 5'd1;
    skip_done_sections();
    return 1'b0;
  endfunction

  function automatic void depuncture_word(input logic signed [SOFT_W-1:0] v,
                                          ref word_t words[$]);
    int    s;
    int    n;
    bit    ended;
    word_t w;
    s = int'(v);
    if (s > SAT_HI) s = SAT_HI;
    if (s < SAT_LO) s = SAT_LO;
    skip_done_sections();
    w.sval   = SOFT_W'(s);
    w.erased = 1'b0;
    w.last   = at_frame_end();
    words.push_back(w);
    ended = step_position();
    n = 1;
    while (!ended && n < MAX_WORDS && !position_kept()) begin
      w.sval   = '0;
      w.erased = 1'b1;
      w.last   = at_frame_end();
      words.push_back(w);
      ended = step_position();
      n++;
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic send_word(input logic signed [SOFT_W-1:0] v, input bit typed,
                           input int zeros, input bit ends);
    word_t batch[$];
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_soft_in <= v;
    do @(posedge clk); while (!in_ready);
    words_in++;
    depuncture_word(v, batch);
    if (typed) begin
      batch.delete();
      batch.push_back('{v, 1'b0, ends && zeros == 0});
      for (int k = 1; k <= zeros; k++)
        batch.push_back('{'0, 1'b1, ends && k == zeros});
    end
    foreach (batch[k]) expected_words.push_back(batch[k]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    for (int s = 0; s < SECTIONS; s++) begin
      if (idx == VEC_REGS[s]) vec_reg[s] = data[VEC_W-1:0];
      if (idx == LEN_REGS[s]) len_reg[s] = data;
    end
    @(posedge clk);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_soft_out, out_erased, out_frame_last};
      words_out++;
      if (got.last === 1'b1) frames_done++;
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word: soft %0d erased %b last %b",
                                got.sval, got.erased, got.last));
      end else begin
        want = expected_words.pop_front();
        if (got.sval !== want.sval || got.erased !== want.erased ||
            got.last !== want.last)
          note_mismatch($sformatf(
            "word %0d: expected soft %0d erased %b last %b, got soft %0d erased %b last %b",
            words_out, want.sval, want.erased, want.last,
            got.sval, got.erased, got.last));
      end
    end
  end

  initial begin
    int               n;
    int               r;
    logic [CDATA_W-1:0] data;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_write) begin
        wait_drained();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
      end else begin
        send_word(DIRECTED[i].sval, DIRECTED[i].typed, DIRECTED[i].zeros, DIRECTED[i].ends);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 67 : 0;
      rx_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 15 : 0;
      for (int ph = 0; ph < 6; ph++) begin
        wait_drained();
        if (mode == 0 && ph == 0) begin
          // longest section, receiver held off so the block backs up
          write_reg(REG_LENGTH_SEC1, 9'h1FF);
          hold_req = 1'b1;
          n = 40;
        end else begin
          for (int s = 0; s < SECTIONS; s++) begin
            if ($urandom_range(0, 1)) begin
              r = $urandom_range(0, 3);
              data[VEC_W-1:0]         = (r == 0) ? VEC_W'($urandom_range(0, 31))
                                                 : VEC_W'($urandom_range(1, 24));
              data[CDATA_W-1:VEC_W]   = (CDATA_W - VEC_W)'($urandom);
              write_reg(VEC_REGS[s], data);
            end
            if ($urandom_range(0, 1)) begin
              r = $urandom_range(0, 99);
              data = (r < 55) ? 9'd0 : (r < 85) ? 9'd1 : (r < 97) ? 9'd2
                     : CDATA_W'($urandom_range(3, 511));
              write_reg(LEN_REGS[s], data);
            end
          end
          n = $urandom_range(8, 32);
        end
        repeat (n) send_word(SOFT_W'($urandom_range(0, 255)), 1'b0, 0, 1'b0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run took %0d soft words in and checked %0d words out, %0d frames closed,",
             words_in, words_out, frames_done);
    $display("%0d register writes across reset, mid-frame and random settings",
             reg_writes);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("** dab_depuncturer: PASSED **");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches,
               expected_words.size());
      $display("** dab_depuncturer: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timed out waiting on a handshake");
    $display("** dab_depuncturer: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dab_dp_pkg.sv
rtl/core/dab_dp_cfg.sv
rtl/core/dab_dp_trk.sv
rtl/core/dab_depuncturer.sv
bench/tb_dab_depuncturer.sv
